[rtl/rgbled_pkg.sv]
// Shared types, register map and helper functions of the RGB LED serial transmitter.
package rgbled_pkg;

   // Configuration register map (word index)
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   typedef enum logic [2:0] {
      REG_ONE_HIGH  = 3'd0,
      REG_ONE_LOW   = 3'd1,
      REG_ZERO_HIGH = 3'd2,
      REG_ZERO_LOW  = 3'd3,
      REG_LATCH_GAP = 3'd4,
      REG_LIMIT     = 3'd5
   } reg_index_type;

   // Register reset values
   localparam logic [7:0]  OneHighReset  = 8'd14;
   localparam logic [7:0]  OneLowReset   = 8'd3;
   localparam logic [7:0]  ZeroHighReset = 8'd3;
   localparam logic [7:0]  ZeroLowReset  = 8'd14;
   localparam logic [15:0] LatchGapReset = 16'd800;
   localparam logic [7:0]  LimitReset    = 8'd100;

   // Frame geometry
   localparam logic [4:0] FrameBits = 5'd24;

   // Line phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_HIGH = 4'b0010,
      PH_LOW  = 4'b0100,
      PH_GAP  = 4'b1000
   } phase_type;

   // Configuration seen by the line sequencer
   typedef struct packed {
      logic [7:0]  one_high_ticks;
      logic [7:0]  one_low_ticks;
      logic [7:0]  zero_high_ticks;
      logic [7:0]  zero_low_ticks;
      logic [15:0] latch_gap_ticks;
      logic [7:0]  channel_limit;
   } cfg_type;

   // Sequencer status for checking
   typedef struct packed {
      phase_type  phase;
      logic [4:0] bits_left;
   } seq_status_type;

   // One result per tick
   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
   } result_type;

   // Remaining ticks after the first one; a count of zero acts as one
   function automatic logic [15:0] ticks_after_first(input logic [15:0] n);
      ticks_after_first = (n == 16'd0) ? 16'd0 : n - 16'd1;
   endfunction

   // Limit one colour channel
   function automatic logic [7:0] clamp_channel(input logic [7:0] v, input logic [7:0] lim);
      clamp_channel = (v > lim) ? lim : v;
   endfunction

endpackage

[rtl/rgb_led_serial_transmitter.sv]
// Top level of the RGB LED serial transmitter: input stage, sequencer, result stage, CSRs.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | opcode, red, green, blue
//   rsp     | out       | rsp_valid/rsp_ready   | line_level, busy_res, accepted
//   csr     | in/out    | psel/penable/pready   | paddr, pwdata, prdata
//
// One transaction per cycle while rsp_ready is high; a request passes the input
// register, then a sequencer step into the result register, before the response.
// The sequencer state advances once per request, so line timing counts transactions.
// Synchronous active-high reset empties both stages, idles the sequencer, resets CSRs.
// A stalled response holds the result register and, once the input stage is full,
// holds off req_ready; no transaction is dropped or repeated.
module rgb_led_serial_transmitter
   import rgbled_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [7:0]              req_red,
   input  logic [7:0]              req_green,
   input  logic [7:0]              req_blue,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_line_level,
   output logic                    rsp_busy_res,
   output logic                    rsp_accepted,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type        cfg;
   result_type     result;
   seq_status_type status;

   logic       in_valid_ff, in_valid_in;
   logic       in_opcode_ff;
   logic [7:0] in_red_ff, in_green_ff, in_blue_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       req_take;
   logic       step;

   rgbled_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Step the sequencer when the input stage holds a transaction and the result has room
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_take  = req_valid && req_ready;

   // Input stage
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff <= req_opcode;
         in_red_ff    <= req_red;
         in_green_ff  <= req_green;
         in_blue_ff   <= req_blue;
      end
   end

   rgbled_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .opcode (in_opcode_ff),
      .red    (in_red_ff),
      .green  (in_green_ff),
      .blue   (in_blue_ff),
      .result (result),
      .status (status)
   );

   // Result stage
   always_comb begin
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_line_level = out_ff.line_level;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_accepted   = out_ff.accepted;

   // A taken colour always starts a high pulse of a busy line
   a_taken_drives_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_line_level && rsp_busy_res))
      else $error("accepted colour without high busy line");

   // Sequencer state moves only on a step
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(status))
      else $error("sequencer state changed without a step");

   // An idle line has no bits left to send
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (status.phase == PH_IDLE) |-> (status.bits_left == 5'd0))
      else $error("idle line with bits pending");

   // A step always fills the result stage
   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("step lost its result");

endmodule

[rtl/rgbled_csr.sv]
// APB-style configuration registers of the RGB LED serial transmitter.
module rgbled_csr
   import rgbled_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_ONE_HIGH:  cfg_in.one_high_ticks  = csr_pwdata[7:0];
            REG_ONE_LOW:   cfg_in.one_low_ticks   = csr_pwdata[7:0];
            REG_ZERO_HIGH: cfg_in.zero_high_ticks = csr_pwdata[7:0];
            REG_ZERO_LOW:  cfg_in.zero_low_ticks  = csr_pwdata[7:0];
            REG_LATCH_GAP: cfg_in.latch_gap_ticks = csr_pwdata[15:0];
            REG_LIMIT:     cfg_in.channel_limit   = csr_pwdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high_ticks  <= OneHighReset;
         cfg_ff.one_low_ticks   <= OneLowReset;
         cfg_ff.zero_high_ticks <= ZeroHighReset;
         cfg_ff.zero_low_ticks  <= ZeroLowReset;
         cfg_ff.latch_gap_ticks <= LatchGapReset;
         cfg_ff.channel_limit   <= LimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      case (index)
         REG_ONE_HIGH:  csr_prdata[7:0]  = cfg_ff.one_high_ticks;
         REG_ONE_LOW:   csr_prdata[7:0]  = cfg_ff.one_low_ticks;
         REG_ZERO_HIGH: csr_prdata[7:0]  = cfg_ff.zero_high_ticks;
         REG_ZERO_LOW:  csr_prdata[7:0]  = cfg_ff.zero_low_ticks;
         REG_LATCH_GAP: csr_prdata[15:0] = cfg_ff.latch_gap_ticks;
         REG_LIMIT:     csr_prdata[7:0]  = cfg_ff.channel_limit;
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/rgbled_seq.sv]
// Line sequencer: bit timing state, colour clamp and frame shifter, one tick per step.
module rgbled_seq
   import rgbled_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  cfg_type        cfg,
   input  logic           opcode,
   input  logic [7:0]     red,
   input  logic [7:0]     green,
   input  logic [7:0]     blue,
   output result_type     result,
   output seq_status_type status
);

   phase_type   phase_ff, phase_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [23:0] shift_ff, shift_in;
   logic [4:0]  bits_ff, bits_in;
   logic [23:0] shifted;
   logic [4:0]  bits_dec;
   logic [7:0]  red_c, green_c, blue_c;
   logic        level;
   logic        taken;

   // Ticks left after the first tick of a high or low pulse for a given bit value
   function automatic logic [15:0] high_len(input logic bit_val, input cfg_type c);
      high_len = ticks_after_first({8'd0, bit_val ? c.one_high_ticks : c.zero_high_ticks});
   endfunction

   function automatic logic [15:0] low_len(input logic bit_val, input cfg_type c);
      low_len = ticks_after_first({8'd0, bit_val ? c.one_low_ticks : c.zero_low_ticks});
   endfunction

   assign shifted  = {shift_ff[22:0], 1'b0};
   assign bits_dec = bits_ff - 5'd1;
   assign red_c    = clamp_channel(red, cfg.channel_limit);
   assign green_c  = clamp_channel(green, cfg.channel_limit);
   assign blue_c   = clamp_channel(blue, cfg.channel_limit);

   // Advance the line phase by one tick, then take a colour if idle
   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      level    = 1'b0;
      taken    = 1'b0;
      case (phase_ff)
         PH_GAP: begin
            if (ticks_ff != 16'd0) begin
               ticks_in = ticks_ff - 16'd1;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_HIGH: begin
            if (ticks_ff != 16'd0) begin
               ticks_in = ticks_ff - 16'd1;
               level    = 1'b1;
            end else begin
               phase_in = PH_LOW;
               ticks_in = low_len(shift_ff[23], cfg);
            end
         end
         PH_LOW: begin
            if (ticks_ff != 16'd0) begin
               ticks_in = ticks_ff - 16'd1;
            end else begin
               shift_in = shifted;
               bits_in  = bits_dec;
               if (bits_dec != 5'd0) begin
                  phase_in = PH_HIGH;
                  ticks_in = high_len(shifted[23], cfg);
                  level    = 1'b1;
               end else begin
                  phase_in = PH_GAP;
                  ticks_in = ticks_after_first(cfg.latch_gap_ticks);
               end
            end
         end
         PH_IDLE: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // Load a new frame: green, red, blue, MSB first
      if (phase_in == PH_IDLE && opcode) begin
         shift_in = {green_c, red_c, blue_c};
         bits_in  = FrameBits;
         phase_in = PH_HIGH;
         ticks_in = high_len(green_c[7], cfg);
         level    = 1'b1;
         taken    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         shift_ff <= '0;
         bits_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
      end
   end

   assign result.line_level = level;
   assign result.busy_res   = (phase_in != PH_IDLE);
   assign result.accepted   = taken;

   assign status.phase     = phase_ff;
   assign status.bits_left = bits_ff;

endmodule
